// File: sv/rgbhsv_pkg.sv
package rgbhsv_pkg;

   localparam int unsigned Scale    = 100;
   localparam int unsigned ChanW    = 8;
   localparam int unsigned QuotW    = 7;
   localparam int unsigned NumW     = 15;
   localparam int unsigned HueW     = 9;
   localparam int unsigned PctW     = 7;
   localparam int unsigned TW       = 10;

   // x / 100 for x < 36000 as (x * HueRecip) >> 22, folded with the factor 60
   localparam int unsigned HueMul   = 60 * 41944;
   localparam int unsigned HueShift = 22;
   // max * 100 / 255 as (max * VMul) >> 24
   localparam int unsigned VMul     = 100 * 65794;
   localparam int unsigned VShift   = 24;

   typedef enum logic [1:0] {
      MAX_RED   = 2'd0,
      MAX_GREEN = 2'd1,
      MAX_BLUE  = 2'd2
   } max_sel_type;

   typedef struct packed {
      logic              neg;
      max_sel_type       sel;
      logic              dzero;
      logic [PctW-1:0]   bright;
   } side_type;

   typedef struct packed {
      logic              valid;
      logic [NumW-1:0]   rem_h;
      logic [NumW-1:0]   rem_s;
      logic [ChanW-1:0]  den_h;
      logic [ChanW-1:0]  den_s;
      logic [QuotW-1:0]  q_h;
      logic [QuotW-1:0]  q_s;
      side_type          side;
   } div_stage_type;

endpackage

// File: sv/rgb_to_hsv_converter.sv
// RGB to HSV converter, one 8-bit-per-channel sample per transfer in, one
// result per transfer out, in order. Fully pipelined: a new sample can be
// taken every cycle while the output is not stalled. There are ten register
// stages (input register, max/min stage, seven stages of the two radix-2
// dividers for hue and saturation, output stage).
// The whole pipe advances whenever the output register is empty or
// being taken, so req_tready follows rsp_tready. Hue is in degrees (0..359),
// saturation and brightness in percent, all truncated; a grey sample has hue 0.
module rgb_to_hsv_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // red[7:0], green[15:8], blue[23:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // hue[8:0], saturation[15:9], brightness[22:16], 0
);
   import rgbhsv_pkg::*;

   logic enable;
   assign enable     = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   // input register
   logic             in_valid_ff;
   logic [ChanW-1:0] red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (enable) begin
         in_valid_ff <= req_tvalid;
      end
      if (enable) begin
         red_ff   <= req_tdata[7:0];
         green_ff <= req_tdata[15:8];
         blue_ff  <= req_tdata[23:16];
      end
   end

   // max / min, numerators
   div_stage_type div_in, div_out;
   logic [ChanW-1:0] mx, mn, dlt, pos_a, pos_b;
   logic [30:0]      vprod;

   always_comb begin
      div_in       = '0;
      mx           = red_ff;
      div_in.side.sel = MAX_RED;
      pos_a        = green_ff;
      pos_b        = blue_ff;
      if (green_ff > mx) begin
         mx = green_ff;
         div_in.side.sel = MAX_GREEN;
      end
      if (blue_ff > mx) begin
         mx = blue_ff;
         div_in.side.sel = MAX_BLUE;
      end
      mn = red_ff;
      if (green_ff < mn) mn = green_ff;
      if (blue_ff < mn) mn = blue_ff;
      dlt = mx - mn;
      case (div_in.side.sel)
         MAX_GREEN: begin pos_a = blue_ff; pos_b = red_ff;   end
         MAX_BLUE:  begin pos_a = red_ff;  pos_b = green_ff; end
         default:   begin pos_a = green_ff; pos_b = blue_ff; end
      endcase
      div_in.valid      = in_valid_ff;
      div_in.side.neg   = pos_a < pos_b;
      div_in.rem_h      = NumW'((pos_a < pos_b ? pos_b - pos_a : pos_a - pos_b) * Scale);
      div_in.rem_s      = NumW'(dlt * 100);
      div_in.den_h      = dlt;
      div_in.den_s      = mx;
      div_in.side.dzero = (dlt == '0);
      vprod             = 31'(mx) * 31'(VMul);
      div_in.side.bright = vprod[VShift +: PctW];
   end

   rgbhsv_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .stage_in  (div_in),
      .stage_out (div_out)
   );

   // hue assembly and output register
   logic [TW-1:0]   t_val;
   logic [TW-1:0]   q_ext;
   logic [31:0]     hprod;
   logic [HueW-1:0] hue_in, hue_ff;
   logic [PctW-1:0] sat_in, sat_ff, bright_ff;
   logic            out_valid_ff;

   always_comb begin
      q_ext = TW'(div_out.q_h);
      case (div_out.side.sel)
         MAX_GREEN: t_val = div_out.side.neg ? TW'(2*Scale) - q_ext : TW'(2*Scale) + q_ext;
         MAX_BLUE:  t_val = div_out.side.neg ? TW'(4*Scale) - q_ext : TW'(4*Scale) + q_ext;
         default: begin
            if (div_out.side.neg && q_ext != '0) t_val = TW'(6*Scale) - q_ext;
            else t_val = q_ext;
         end
      endcase
      hprod  = 32'(t_val) * 32'(HueMul);
      hue_in = div_out.side.dzero ? '0 : hprod[HueShift +: HueW];
      sat_in = div_out.side.dzero ? '0 : div_out.q_s;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= div_out.valid;
      end
      if (enable) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= div_out.side.bright;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, bright_ff, sat_ff, hue_ff};

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (hue_ff < HueW'(360) && sat_ff <= PctW'(100) && bright_ff <= PctW'(100)))
      else $error("result out of range");

   a_grey_hue: assert property (@(posedge clock) disable iff (reset)
      (enable && div_out.valid && div_out.side.dzero) |=> (hue_ff == '0 && sat_ff == '0))
      else $error("grey sample gave non-zero hue or saturation");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input taken while output stalled");

endmodule

// File: sv/rgbhsv_div.sv
module rgbhsv_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  rgbhsv_pkg::div_stage_type stage_in,
   output rgbhsv_pkg::div_stage_type stage_out
);
   import rgbhsv_pkg::*;

   div_stage_type pipe_ff [QuotW+1];
   div_stage_type pipe_in [QuotW+1];

   always_comb begin
      logic [NumW-1:0] sh_h;
      logic [NumW-1:0] sh_s;
      pipe_in[0] = stage_in;
      for (int k = 1; k <= QuotW; k++) begin
         pipe_in[k] = pipe_ff[k-1];
         sh_h = NumW'(pipe_ff[k-1].den_h) << (QuotW - k);
         sh_s = NumW'(pipe_ff[k-1].den_s) << (QuotW - k);
         if (pipe_ff[k-1].rem_h >= sh_h) begin
            pipe_in[k].rem_h = pipe_ff[k-1].rem_h - sh_h;
            pipe_in[k].q_h[QuotW-k] = 1'b1;
         end
         if (pipe_ff[k-1].rem_s >= sh_s) begin
            pipe_in[k].rem_s = pipe_ff[k-1].rem_s - sh_s;
            pipe_in[k].q_s[QuotW-k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= QuotW; k++) begin
         if (reset) begin
            pipe_ff[k] <= '0;
         end else if (enable) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign stage_out = pipe_ff[QuotW];

endmodule

// File: tb/sv/rgb_to_hsv_converter_test.sv
module rgb_to_hsv_converter_test;
   import rgbhsv_pkg::*;

   typedef struct packed {
      logic [HueW-1:0] hue;
      logic [PctW-1:0] sat;
      logic [PctW-1:0] bright;
   } hsv_type;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      bit         known;
      hsv_type    want;
   } pixel_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;

   hsv_type     hsv_queue[$];
   int          mismatches;
   int          results;
   int          send_idle;
   int          recv_stall;

   rgb_to_hsv_converter dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic hsv_type rgb_to_hsv(input logic [7:0] r8, input logic [7:0] g8,
                                          input logic [7:0] b8);
      int r, g, b, hi, lo, span, t;
      max_sel_type top;
      hsv_type res;
      r = int'(r8); g = int'(g8); b = int'(b8);
      hi = r; top = MAX_RED;
      if (g > hi) begin hi = g; top = MAX_GREEN; end
      if (b > hi) begin hi = b; top = MAX_BLUE; end
      lo = r;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      span = hi - lo;
      if (span == 0)
         t = 0;
      else begin
         case (top)
            MAX_RED: begin
               t = ((g - b) * 100) / span;
               if (t < 0) t += 600;
            end
            MAX_GREEN: t = ((b - r) * 100) / span + 200;
            default:   t = ((r - g) * 100) / span + 400;
         endcase
         t = (60 * t) / 100;
      end
      res.hue    = HueW'(t);
      res.sat    = PctW'((hi == 0) ? 0 : (span * 100) / hi);
      res.bright = PctW'((hi * 100) / 255);
      return res;
   endfunction

   // receiver
   always @(posedge clock) begin
      hsv_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hue    = rsp_tdata[8:0];
         got.sat    = rsp_tdata[15:9];
         got.bright = rsp_tdata[22:16];
         results++;
         if (hsv_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: hue %0d sat %0d bright %0d",
                        got.hue, got.sat, got.bright);
         end else begin
            want = hsv_queue.pop_front();
            if (got !== want || rsp_tdata[23] !== 1'b0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result %0d: expected h %0d s %0d v %0d, got h %0d s %0d v %0d",
                           results, want.hue, want.sat, want.bright,
                           got.hue, got.sat, got.bright);
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b, input bit known, input hsv_type want);
      hsv_type model;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {b, g, r};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      model = rgb_to_hsv(r, g, b);
      if (known && model !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row %0d,%0d,%0d: typed h %0d s %0d v %0d",
                     r, g, b, want.hue, want.sat, want.bright);
      end
      hsv_queue.push_back(model);
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (hsv_queue.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
   endtask

   pixel_row_type pixel_table[21] = '{
      '{8'd0,   8'd0,   8'd0,   1, '{9'd0,   7'd0,   7'd0}},
      '{8'd255, 8'd255, 8'd255, 1, '{9'd0,   7'd0,   7'd100}},
      '{8'd128, 8'd128, 8'd128, 1, '{9'd0,   7'd0,   7'd50}},
      '{8'd255, 8'd0,   8'd0,   1, '{9'd0,   7'd100, 7'd100}},
      '{8'd0,   8'd255, 8'd0,   1, '{9'd120, 7'd100, 7'd100}},
      '{8'd0,   8'd0,   8'd255, 1, '{9'd240, 7'd100, 7'd100}},
      '{8'd255, 8'd255, 8'd0,   1, '{9'd60,  7'd100, 7'd100}},
      '{8'd0,   8'd255, 8'd255, 1, '{9'd180, 7'd100, 7'd100}},
      '{8'd255, 8'd0,   8'd255, 1, '{9'd300, 7'd100, 7'd100}},
      '{8'd1,   8'd0,   8'd0,   1, '{9'd0,   7'd100, 7'd0}},
      '{8'd0,   8'd0,   8'd1,   1, '{9'd240, 7'd100, 7'd0}},
      '{8'd255, 8'd0,   8'd1,   0, '{9'd0,   7'd0,   7'd0}},
      '{8'd255, 8'd1,   8'd0,   0, '{9'd0,   7'd0,   7'd0}},
      '{8'd0,   8'd255, 8'd254, 0, '{9'd0,   7'd0,   7'd0}},
      '{8'd254, 8'd255, 8'd0,   0, '{9'd0,   7'd0,   7'd0}},
      '{8'd1,   8'd0,   8'd255, 0, '{9'd0,   7'd0,   7'd0}},
      '{8'd0,   8'd1,   8'd255, 0, '{9'd0,   7'd0,   7'd0}},
      '{8'd200, 8'd100, 8'd50,  0, '{9'd0,   7'd0,   7'd0}},
      '{8'd170, 8'd85,  8'd170, 0, '{9'd0,   7'd0,   7'd0}},
      '{8'd10,  8'd20,  8'd15,  0, '{9'd0,   7'd0,   7'd0}},
      '{8'd85,  8'd170, 8'd255, 0, '{9'd0,   7'd0,   7'd0}}
   };

   initial begin
      int phase, n;
      logic [7:0] r, g, b;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      send_idle  = 0;
      recv_stall = 0;
      mismatches = 0;
      results    = 0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (pixel_table[i])
         send_pixel(pixel_table[i].red, pixel_table[i].green, pixel_table[i].blue,
                    pixel_table[i].known, pixel_table[i].want);

      for (phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 48; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 48; end
            3: begin send_idle = 17; recv_stall = 17; end
            default: begin send_idle = 0; recv_stall = 0; end
         endcase
         for (n = 0; n < 400; n++) begin
            r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
            case ($urandom_range(7))
               0: g = r;
               1: b = r;
               2: b = g;
               3: begin g = r; b = r; end
               default: ;
            endcase
            send_pixel(r, g, b, 0, '0);
         end
         if (phase == 2) drain();
      end

      drain();
      repeat (30) @(negedge clock);
      if (mismatches == 0 && hsv_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: files.f
sv/rgbhsv_pkg.sv
sv/rgbhsv_div.sv
sv/rgb_to_hsv_converter.sv
tb/sv/rgb_to_hsv_converter_test.sv
